FILE: hdl/frs_pkg.sv
// Shared types and constants of the alternate-row field shifter.
`timescale 1ns / 1ps
`default_nettype none
package frs_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_ROW_WIDTH   = 1'd0;
  localparam cfg_idx_t CFG_FIELD_SHIFT = 1'd1;

  // Register widths and reset values
  localparam int ROW_WIDTH_W = 13;
  localparam int SHIFT_W     = 8;
  localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RST   = 13'd720;
  localparam logic [SHIFT_W-1:0]     FIELD_SHIFT_RST = 8'd2;
  localparam int SHIFT_LIMIT = 100;

  // At most this many output words follow from one input word
  localparam int MAX_RESULTS = 51;
  localparam int RES_CNT_W   = 6;

  // One output word handed from the column sequencer to the output register
  typedef struct packed {
    logic fire;
    logic row_end;
    logic last;
  } frs_emit_t;

endpackage
`default_nettype wire

FILE: hdl/frs_cfg_regs.sv
// Configuration registers and the derived row width and per-parity shifts.
`timescale 1ns / 1ps
`default_nettype none
module frs_cfg_regs #(
  parameter int MAX_WIDTH = 4096,
  parameter int MAX_DELAY = 64,
  parameter int WW        = 13
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire frs_pkg::cfg_idx_t              cfg_index,
  input  wire logic [frs_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [WW-1:0]                       width_eff,
  output logic signed [frs_pkg::SHIFT_W-1:0]  shift_even,
  output logic signed [frs_pkg::SHIFT_W-1:0]  shift_odd
);
  import frs_pkg::*;

  localparam logic signed [8:0] SL    = 9'(SHIFT_LIMIT);
  localparam logic signed [8:0] MD    = 9'(MAX_DELAY);
  localparam logic [15:0]       MAXW  = 16'(MAX_WIDTH);

  logic [ROW_WIDTH_W-1:0] row_width_r;
  logic [SHIFT_W-1:0]     field_shift_r;
  logic signed [8:0]      p9;
  logic signed [8:0]      ps;
  logic signed [8:0]      half;
  logic signed [8:0]      rem;
  logic [15:0]            w16;
  logic [15:0]            we16;

  function automatic logic signed [8:0] lim(input logic signed [8:0] v);
    if (v < -MD) return -MD;
    if (v > MD) return MD;
    return v;
  endfunction

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_width_r   <= ROW_WIDTH_RST;
      field_shift_r <= FIELD_SHIFT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROW_WIDTH:   row_width_r   <= cfg_data[ROW_WIDTH_W-1:0];
        CFG_FIELD_SHIFT: field_shift_r <= cfg_data[SHIFT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    p9 = signed'({field_shift_r[SHIFT_W-1], field_shift_r});
    if (p9 > SL) ps = SL;
    else if (p9 < -SL) ps = -SL;
    else ps = p9;
    // half rounds toward zero
    if (ps[8]) half = (ps + 9'sd1) >>> 1;
    else half = ps >>> 1;
    rem = ps - half;
    shift_even = SHIFT_W'(lim(-half));
    shift_odd  = SHIFT_W'(lim(rem));

    w16 = {3'd0, row_width_r};
    if (w16 == 16'd0) we16 = 16'd1;
    else if (w16 > MAXW) we16 = MAXW;
    else we16 = w16;
    width_eff = WW'(we16);
  end

endmodule
`default_nettype wire

FILE: hdl/frs_col_seq.sv
// Input word register, row state and the per-column emit sequencer.
`timescale 1ns / 1ps
`default_nettype none
module frs_col_seq #(
  parameter int WW         = 13,
  parameter int PIXEL_BITS = 64
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [PIXEL_BITS-1:0]                 in_pixel,
  input  wire logic                                  in_frame_start,
  input  wire logic [WW-1:0]                         width_eff,
  input  wire logic signed [frs_pkg::SHIFT_W-1:0]    shift_even,
  input  wire logic signed [frs_pkg::SHIFT_W-1:0]    shift_odd,
  input  wire logic                                  slot_free,
  output frs_pkg::frs_emit_t                         emit,
  output logic [PIXEL_BITS-1:0]                      emit_pixel
);
  import frs_pkg::*;

  localparam int SW = WW + 2;

  logic                   hold_v_r;
  logic [PIXEL_BITS-1:0]  hold_pix_r;
  logic [WW-1:0]          hold_c_r;
  logic [WW-1:0]          col_r;
  logic [WW-1:0]          emit_r;
  logic                   odd_r;
  logic [PIXEL_BITS-1:0]  fp_r;
  logic [RES_CNT_W-1:0]   n_r;

  logic signed [SHIFT_W-1:0] d;
  logic [WW-1:0]  w_m1;
  logic [WW:0]    j1;
  logic [1:0]     cmp0;
  logic [1:0]     cmp1;
  logic           cond0;
  logic           cond1;
  logic           fire;
  logic           done;
  logic           accept;
  logic           row_wrap;
  logic [WW-1:0]  emit_adv;
  logic [WW-1:0]  col_nxt;
  logic [WW-1:0]  emit_nxt;
  logic           odd_nxt;
  logic [WW-1:0]  c_nxt;

  // {source <= column, source == column} for output column j
  function automatic logic [1:0] src_cmp(input logic [WW:0] j,
                                         input logic signed [SHIFT_W-1:0] dd,
                                         input logic [WW-1:0] w,
                                         input logic [WW-1:0] c);
    logic signed [SW-1:0] diff;
    logic signed [SW-1:0] wm1;
    logic signed [SW-1:0] cs;
    logic signed [SW-1:0] src;
    diff = signed'({1'b0, j}) - SW'(dd);
    wm1  = signed'({2'b00, w}) - SW'(1);
    cs   = signed'({2'b00, c});
    if (diff < 0) src = '0;
    else if (diff > wm1) src = wm1;
    else src = diff;
    return {src <= cs, src == cs};
  endfunction

  always_comb begin
    d     = odd_r ? shift_odd : shift_even;
    w_m1  = width_eff - 1'b1;
    j1    = {1'b0, emit_r} + 1'b1;
    cmp0  = src_cmp({1'b0, emit_r}, d, width_eff, hold_c_r);
    cmp1  = src_cmp(j1, d, width_eff, hold_c_r);
    cond0 = (emit_r < width_eff) && (n_r < RES_CNT_W'(MAX_RESULTS)) && cmp0[1];
    cond1 = (j1 < {1'b0, width_eff})
            && (({1'b0, n_r} + 1'b1) < (RES_CNT_W + 1)'(MAX_RESULTS)) && cmp1[1];

    fire   = hold_v_r && cond0 && slot_free;
    done   = hold_v_r && (!cond0 || (slot_free && !cond1));
    in_stall = hold_v_r && !done;
    accept = in_valid && !in_stall;

    emit.fire    = fire;
    emit.row_end = (emit_r == w_m1);
    emit.last    = !cond1;
    emit_pixel   = cmp0[0] ? hold_pix_r : fp_r;

    // advance the row state when the held word retires
    row_wrap = (hold_c_r == w_m1);
    emit_adv = emit_r + WW'(fire);
    col_nxt  = col_r;
    emit_nxt = emit_adv;
    odd_nxt  = odd_r;
    if (done) begin
      if (row_wrap) begin
        col_nxt  = '0;
        emit_nxt = '0;
        odd_nxt  = ~odd_r;
      end else begin
        col_nxt = hold_c_r + 1'b1;
      end
    end
    if (accept && in_frame_start) begin
      col_nxt  = '0;
      emit_nxt = '0;
      odd_nxt  = 1'b0;
    end
    c_nxt = (col_nxt > w_m1) ? w_m1 : col_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
      col_r    <= '0;
      emit_r   <= '0;
      odd_r    <= 1'b0;
      n_r      <= '0;
      fp_r     <= '0;
    end else begin
      hold_v_r <= accept ? 1'b1 : (hold_v_r && !done);
      col_r    <= col_nxt;
      emit_r   <= emit_nxt;
      odd_r    <= odd_nxt;
      n_r      <= done ? '0 : n_r + RES_CNT_W'(fire);
      if (accept && (c_nxt == '0)) begin
        fp_r <= in_pixel;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_pix_r <= in_pixel;
      hold_c_r   <= c_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/frs_out_reg.sv
// Output word register with valid and stall.
`timescale 1ns / 1ps
`default_nettype none
module frs_out_reg #(
  parameter int PIXEL_BITS = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire frs_pkg::frs_emit_t    emit,
  input  wire logic [PIXEL_BITS-1:0] emit_pixel,
  output logic                       slot_free,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [PIXEL_BITS-1:0]      out_shifted_pixel,
  output logic                       out_row_end,
  output logic                       out_last
);
  import frs_pkg::*;

  logic                  valid_r;
  logic [PIXEL_BITS-1:0] pix_r;
  logic                  row_end_r;
  logic                  last_r;

  assign slot_free         = !valid_r || !out_stall;
  assign out_valid         = valid_r;
  assign out_shifted_pixel = pix_r;
  assign out_row_end       = row_end_r;
  assign out_last          = last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (emit.fire) begin
      valid_r <= 1'b1;
    end else if (slot_free) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit.fire) begin
      pix_r     <= emit_pixel;
      row_end_r <= emit.row_end;
      last_r    <= emit.last;
    end
  end

endmodule
`default_nettype wire

FILE: hdl/field_alternate_row_shifter_core.sv
// Top level of the alternate-row horizontal field shifter.
`timescale 1ns / 1ps
`default_nettype none
// Streams one image plane in raster order, one pixel word per clock while
// in_stall is low, and shifts alternate rows in opposite directions. The
// plane shift is split into a half (rounded toward zero) and the remainder:
// odd rows move right by the remainder and repeat their first pixel into the
// gap, even rows move left by the half and repeat their last pixel at the
// end. Each output column goes out as soon as the input pixel it copies has
// arrived, so a right-shifted row answers its first input with a burst of
// up to remainder+1 words, the first inputs of a left-shifted row give no
// word, and its last input emits the trailing repeats. The column sequencer
// emits one word a cycle, while the output register is free, into that single
// register, and in_stall rises while such a burst drains or while a stalled
// output word blocks the next one. An accepted input word is held in the
// input word register; its first output word is registered in the output
// register and shows on out_valid. frame_start restarts row parity and the
// column count before the pixel is taken. Write the row width and field shift
// registers only when the block is idle; cfg_ready is always high.
module field_alternate_row_shifter_core #(
  parameter int MAX_WIDTH  = 4096,
  parameter int MAX_DELAY  = 64,
  parameter int PIXEL_BITS = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  // input words
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [PIXEL_BITS-1:0]          in_pixel,
  input  wire logic                           in_frame_start,
  // output words
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [PIXEL_BITS-1:0]               out_shifted_pixel,
  output logic                                out_row_end,
  output logic                                out_last,
  // configuration writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire frs_pkg::cfg_idx_t              cfg_index,
  input  wire logic [frs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import frs_pkg::*;

  // Column counters must hold the row width itself
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [WW-1:0]             width_eff;
  logic signed [SHIFT_W-1:0] shift_even;
  logic signed [SHIFT_W-1:0] shift_odd;
  logic                      slot_free;
  frs_emit_t                 emit;
  logic [PIXEL_BITS-1:0]     emit_pixel;

  // Hold the registers; derive clamped width and per-parity shifts
  frs_cfg_regs #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_DELAY (MAX_DELAY),
    .WW        (WW)
  ) u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .width_eff  (width_eff),
    .shift_even (shift_even),
    .shift_odd  (shift_odd)
  );

  // Take in a word, then emit each output column whose source has arrived
  frs_col_seq #(
    .WW         (WW),
    .PIXEL_BITS (PIXEL_BITS)
  ) u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_pixel       (in_pixel),
    .in_frame_start (in_frame_start),
    .width_eff      (width_eff),
    .shift_even     (shift_even),
    .shift_odd      (shift_odd),
    .slot_free      (slot_free),
    .emit           (emit),
    .emit_pixel     (emit_pixel)
  );

  // Register the result; it holds while the sink stalls
  frs_out_reg #(
    .PIXEL_BITS (PIXEL_BITS)
  ) u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .emit              (emit),
    .emit_pixel        (emit_pixel),
    .slot_free         (slot_free),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_shifted_pixel (out_shifted_pixel),
    .out_row_end       (out_row_end),
    .out_last          (out_last)
  );

endmodule
`default_nettype wire

FILE: hdl/frs_checker.sv
// Port-level checks of the field shifter and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
module frs_checker #(
  parameter int PIXEL_BITS = 64
) (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic [PIXEL_BITS-1:0]          in_pixel,
  input wire logic                           in_frame_start,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic [PIXEL_BITS-1:0]          out_shifted_pixel,
  input wire logic                           out_row_end,
  input wire logic                           out_last,
  input wire logic                           cfg_ready
);

  // Reset empties the output register
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set right after reset");

  // A burst continues without bubbles until its last word
  a_burst_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> out_valid)
    else $error("gap inside a burst of output words");

  // A stalled output word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_shifted_pixel)
      && $stable(out_row_end) && $stable(out_last))
    else $error("stalled output word changed");

  // A stalled input word holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_pixel) && $stable(in_frame_start))
    else $error("stalled input word changed");

  // Configuration writes are never refused
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n) cfg_ready)
    else $error("cfg_ready dropped");

endmodule

bind field_alternate_row_shifter_core frs_checker #(.PIXEL_BITS(PIXEL_BITS)) u_frs_chk (.*);
`default_nettype wire
